/* hw/rtl/ddcc_pkg.sv */
package ddcc_pkg;

    localparam int unsigned CNT_W = 32;
    localparam int unsigned WIN_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd50;
    localparam logic [CNT_W-1:0] RUN_LENGTH_RESET = 32'd86400000;
    localparam logic [CNT_W-1:0] LOG_PERIOD_RESET = 32'd60000;

    typedef enum logic [1:0] {
        FN_PULSE_ONE = 2'd0,
        FN_PULSE_TWO = 2'd1,
        FN_START     = 2'd2,
        FN_TICK      = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW     = 2'd0,
        CFG_RUN_LENGTH = 2'd1,
        CFG_LOG_PERIOD = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_WAITING  = 2'd0,
        PH_RUNNING  = 2'd2,
        PH_FINISHED = 2'd3
    } t_phase;

    typedef struct packed {
        logic [WIN_W-1:0] window_us;
        logic [CNT_W-1:0] run_length_ms;
        logic [CNT_W-1:0] log_period_ms;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] elapsed_ms;
        logic [CNT_W-1:0] hits_one;
        logic [CNT_W-1:0] hits_two;
        logic [CNT_W-1:0] matches_res;
        logic             final_record;
    } t_record;

endpackage

/* hw/rtl/ddcc_cfg_regs.sv */
module ddcc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ddcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ddcc_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                          o_cfg_ready,
    output ddcc_pkg::t_cfg                o_cfg
);

    ddcc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_us     <= ddcc_pkg::WINDOW_RESET;
            r_cfg.run_length_ms <= ddcc_pkg::RUN_LENGTH_RESET;
            r_cfg.log_period_ms <= ddcc_pkg::LOG_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ddcc_pkg::CFG_WINDOW: begin
                    r_cfg.window_us <= i_cfg_data[ddcc_pkg::WIN_W-1:0];
                end
                ddcc_pkg::CFG_RUN_LENGTH: begin
                    r_cfg.run_length_ms <= i_cfg_data;
                end
                ddcc_pkg::CFG_LOG_PERIOD: begin
                    r_cfg.log_period_ms <= i_cfg_data;
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ddcc_core.sv */
module ddcc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [1:0]                 i_func,
    input  logic [ddcc_pkg::CNT_W-1:0] i_now_us,
    input  ddcc_pkg::t_cfg             i_cfg,
    output ddcc_pkg::t_record          o_rec
);

    ddcc_pkg::t_phase            r_phase,    n_phase;
    logic [ddcc_pkg::CNT_W-1:0]  r_ones,     n_ones;
    logic [ddcc_pkg::CNT_W-1:0]  r_twos,     n_twos;
    logic [ddcc_pkg::CNT_W-1:0]  r_match,    n_match;
    logic [ddcc_pkg::CNT_W-1:0]  r_last_one, n_last_one;
    logic [ddcc_pkg::CNT_W-1:0]  r_last_two, n_last_two;
    logic [ddcc_pkg::CNT_W-1:0]  r_run,      n_run;
    logic [ddcc_pkg::CNT_W-1:0]  r_since,    n_since;

    logic [ddcc_pkg::CNT_W-1:0]  gap_us;
    logic [ddcc_pkg::CNT_W-1:0]  win_ext;
    logic [ddcc_pkg::CNT_W-1:0]  run_inc;
    logic [ddcc_pkg::CNT_W-1:0]  since_inc;

    assign win_ext   = {{(ddcc_pkg::CNT_W-ddcc_pkg::WIN_W){1'b0}}, i_cfg.window_us};
    // wrapping gap to the other channel's last stamp
    assign gap_us    = (i_func == ddcc_pkg::FN_PULSE_ONE) ? (i_now_us - r_last_two)
                                                          : (i_now_us - r_last_one);
    assign run_inc   = r_run + 1'b1;
    assign since_inc = r_since + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_ones     = r_ones;
        n_twos     = r_twos;
        n_match    = r_match;
        n_last_one = r_last_one;
        n_last_two = r_last_two;
        n_run      = r_run;
        n_since    = r_since;

        o_rec.valid        = 1'b0;
        o_rec.elapsed_ms   = run_inc;
        o_rec.hits_one     = r_ones;
        o_rec.hits_two     = r_twos;
        o_rec.matches_res  = r_match;
        o_rec.final_record = 1'b0;

        if (i_step) begin
            case (i_func)
                ddcc_pkg::FN_PULSE_ONE: begin
                    n_ones     = r_ones + 1'b1;
                    n_last_one = i_now_us;
                    if (gap_us <= win_ext) begin
                        n_match = r_match + 1'b1;
                    end
                end
                ddcc_pkg::FN_PULSE_TWO: begin
                    n_twos     = r_twos + 1'b1;
                    n_last_two = i_now_us;
                    if (gap_us <= win_ext) begin
                        n_match = r_match + 1'b1;
                    end
                end
                ddcc_pkg::FN_START: begin
                    if (r_phase == ddcc_pkg::PH_WAITING) begin
                        n_ones  = '0;
                        n_twos  = '0;
                        n_match = '0;
                        n_run   = '0;
                        n_since = '0;
                        n_phase = ddcc_pkg::PH_RUNNING;
                    end
                end
                default: begin
                    if (r_phase == ddcc_pkg::PH_RUNNING) begin
                        n_run   = run_inc;
                        n_since = since_inc;
                        if (run_inc >= i_cfg.run_length_ms) begin
                            o_rec.valid        = 1'b1;
                            o_rec.final_record = 1'b1;
                            n_phase            = ddcc_pkg::PH_FINISHED;
                        end else if (since_inc >= i_cfg.log_period_ms) begin
                            o_rec.valid = 1'b1;
                            n_since     = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ddcc_pkg::PH_WAITING;
            r_ones     <= '0;
            r_twos     <= '0;
            r_match    <= '0;
            r_last_one <= '0;
            r_last_two <= '0;
            r_run      <= '0;
            r_since    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_ones     <= n_ones;
            r_twos     <= n_twos;
            r_match    <= n_match;
            r_last_one <= n_last_one;
            r_last_two <= n_last_two;
            r_run      <= n_run;
            r_since    <= n_since;
        end
    end

endmodule

/* hw/rtl/dual_detector_coincidence_counter.sv */
// Two-detector coincidence counter.
//
// Input channel (i_in_valid / o_in_ready): one transaction per event,
// i_func selects pulse on detector one, pulse on detector two, start, or
// millisecond tick; i_now_us is the pulse timestamp.
// Output channel (o_out_valid / i_out_ready): a log record of elapsed time
// and the three counts, o_final_record set on the record that ends the run.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 window,
// 1 run length, 2 log period. Write only while the block is idle.
//
// An event is registered on acceptance, evaluated against the counter
// state once the output slot is free or being emptied, and its record (if
// any) is loaded into the output register. Throughput: one event per cycle
// while no record is held on a stalled output; the state update is a single
// compare-and-increment pass between the input and output registers.
// Stall: while a record waits on the output, the evaluation stage holds;
// o_in_ready stays high only until the input register holds an event.
// Reset (synchronous, active low): counts, stamps and timers cleared,
// waiting phase, registers back to their defaults, both stages empty.
module dual_detector_coincidence_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // event input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_func,
    input  logic [ddcc_pkg::CNT_W-1:0]     i_now_us,
    // record output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ddcc_pkg::CNT_W-1:0]     o_elapsed_ms,
    output logic [ddcc_pkg::CNT_W-1:0]     o_hits_one,
    output logic [ddcc_pkg::CNT_W-1:0]     o_hits_two,
    output logic [ddcc_pkg::CNT_W-1:0]     o_matches_res,
    output logic                           o_final_record,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ddcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ddcc_pkg::CNT_W-1:0]     i_cfg_data
);

    ddcc_pkg::t_cfg    cfg;
    ddcc_pkg::t_record rec;

    // input register
    logic                       r_in_valid;
    logic [1:0]                 r_in_func;
    logic [ddcc_pkg::CNT_W-1:0] r_in_now;

    // output register
    logic                       r_out_valid;
    ddcc_pkg::t_record          r_out;

    logic advance;   // evaluation stage may retire its event
    logic step;      // event evaluated this cycle

    // Stage moves when the output slot is free or being emptied.
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    ddcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ddcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_func   (r_in_func),
        .i_now_us (r_in_now),
        .i_cfg    (cfg),
        .o_rec    (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func <= i_func;
            r_in_now  <= i_now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= rec.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && rec.valid) begin
            r_out <= rec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_elapsed_ms   = r_out.elapsed_ms;
    assign o_hits_one     = r_out.hits_one;
    assign o_hits_two     = r_out.hits_two;
    assign o_matches_res  = r_out.matches_res;
    assign o_final_record = r_out.final_record;

endmodule

/* hw/rtl/ddcc_checker.sv */
module ddcc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [ddcc_pkg::CNT_W-1:0] o_elapsed_ms,
    input logic                       o_final_record
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("record valid after reset");

    // reset empties the input register
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // stalled record keeps its elapsed time
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_elapsed_ms)))
        else $error("stalled record changed");

    // nothing follows the final record
    a_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_final_record) |=> !o_out_valid)
        else $error("record after final record");

endmodule

bind dual_detector_coincidence_counter ddcc_checker u_ddcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_elapsed_ms   (o_elapsed_ms),
    .o_final_record (o_final_record)
);
